/* design/rpn_pkg.sv */
// Package for the RPN stack calculator: widths, action and status codes,
// and the request type passed to the shared arithmetic unit.
// No dependencies.
package rpn_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 4;
	localparam int HT_W        = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = $clog2(STACK_DEPTH);

	// Field widths
	localparam int WORD_W   = 64;
	localparam int CNT_W    = $clog2(WORD_W);
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 3;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUO  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_REM  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_END  = 3'd6;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RESULT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISPLACED = 3'd5;
	localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd6;

	// Operations of the shared arithmetic unit
	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_QUO,
		ALU_REM
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

/* design/rpn_alu.sv */
// Shared arithmetic unit of the RPN calculator: add/subtract in one step,
// shift-add multiply and restoring divide, one bit per cycle.
// Depends on rpn_pkg.
module rpn_alu (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rpn_pkg::alu_req_t                req,
	input  logic signed [rpn_pkg::WORD_W-1:0] a,
	input  logic signed [rpn_pkg::WORD_W-1:0] b,
	output logic                             done,
	output logic signed [rpn_pkg::WORD_W-1:0] res
);

	typedef enum logic [1:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_FIX
	} alu_state_t;

	alu_state_t                   st_q;
	logic [rpn_pkg::CNT_W-1:0]    cnt_q;
	logic [rpn_pkg::WORD_W-1:0]   x_q;    // multiplicand, or dividend/quotient
	logic [rpn_pkg::WORD_W-1:0]   y_q;    // multiplier, or divisor magnitude
	logic [rpn_pkg::WORD_W-1:0]   acc_q;  // product, or partial remainder
	logic                         neg_q;
	logic                         rem_sel_q;
	logic                         done_q;
	logic [rpn_pkg::WORD_W-1:0]   res_q;

	logic [rpn_pkg::WORD_W-1:0]   mag_a;
	logic [rpn_pkg::WORD_W-1:0]   mag_b;
	logic [rpn_pkg::WORD_W-1:0]   div_shift;
	logic                         div_fits;
	logic [rpn_pkg::WORD_W-1:0]   fix_val;
	logic                         last_step;

	// Magnitudes of the operands for division
	assign mag_a = a[rpn_pkg::WORD_W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[rpn_pkg::WORD_W-1] ? (~b + 1'b1) : b;

	// One restoring step: partial remainder stays below 2^63
	assign div_shift = {acc_q[rpn_pkg::WORD_W-2:0], x_q[rpn_pkg::WORD_W-1]};
	assign div_fits  = (div_shift >= y_q);

	assign fix_val   = rem_sel_q ? acc_q : x_q;
	assign last_step = (cnt_q == rpn_pkg::CNT_W'(rpn_pkg::WORD_W - 1));

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// add and subtract finish at start, the others after the fix step
			done_q <= (st_q == A_FIX) ||
				(st_q == A_IDLE && req.start &&
				(req.op == rpn_pkg::ALU_ADD || req.op == rpn_pkg::ALU_SUB));
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= '0;
						case (req.op)
							rpn_pkg::ALU_ADD: begin
								res_q <= a + b;
							end
							rpn_pkg::ALU_SUB: begin
								res_q <= a - b;
							end
							rpn_pkg::ALU_MUL: begin
								x_q       <= a;
								y_q       <= b;
								acc_q     <= '0;
								neg_q     <= 1'b0;
								rem_sel_q <= 1'b1;
								st_q      <= A_MUL;
							end
							default: begin
								x_q       <= mag_a;
								y_q       <= mag_b;
								acc_q     <= '0;
								rem_sel_q <= (req.op == rpn_pkg::ALU_REM);
								neg_q     <= (req.op == rpn_pkg::ALU_REM)
									? a[rpn_pkg::WORD_W-1]
									: (a[rpn_pkg::WORD_W-1] ^ b[rpn_pkg::WORD_W-1]);
								st_q      <= A_DIV;
							end
						endcase
					end
				end
				A_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q   <= {x_q[rpn_pkg::WORD_W-2:0], 1'b0};
					y_q   <= {1'b0, y_q[rpn_pkg::WORD_W-1:1]};
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						st_q <= A_FIX;
					end
				end
				A_DIV: begin
					acc_q <= div_fits ? (div_shift - y_q) : div_shift;
					x_q   <= {x_q[rpn_pkg::WORD_W-2:0], div_fits};
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						st_q <= A_FIX;
					end
				end
				A_FIX: begin
					// sign correction of quotient or remainder
					res_q <= neg_q ? (~fix_val + 1'b1) : fix_val;
					st_q  <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* design/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: stack memory, item sequencer and
// result register. Depends on rpn_pkg and rpn_alu.
//
//  channel  handshake            payload
//  -------  -------------------  ----------------------------------------
//  input    in_valid / in_stall  action, operand_value
//  output   out_valid / out_stall status, result_value, stack_depth
//
// Push, end, ignored codes, faults and halted items pass from acceptance
// straight to the emit state; operators pass through the start and wait
// states first. Multiply, quotient and remainder run 64 steps of the
// shared bit-serial unit, then its fix step. in_stall drops as the result
// appears. One transaction is in work at a time.
// in_stall is high while a transaction is in work or its result cannot be
// placed in the output register. Reset empties the stack and clears halt.
module rpn_stack_calculator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rpn_pkg::ACTION_W-1:0]          action,
	input  logic signed [rpn_pkg::WORD_W-1:0]     operand_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rpn_pkg::STATUS_W-1:0]          status,
	output logic signed [rpn_pkg::WORD_W-1:0]     result_value,
	output logic [rpn_pkg::DEPTH_W-1:0]           stack_depth
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t                             state_q;
	logic [rpn_pkg::HT_W-1:0]           height_q;
	logic                               halted_q;
	logic [rpn_pkg::WORD_W-1:0]         top_q;
	rpn_pkg::alu_op_t                   op_q;
	logic [rpn_pkg::STATUS_W-1:0]       pend_status_q;
	logic [rpn_pkg::WORD_W-1:0]         pend_value_q;

	logic                               out_valid_q;
	logic [rpn_pkg::STATUS_W-1:0]       out_status_q;
	logic [rpn_pkg::WORD_W-1:0]         out_value_q;
	logic [rpn_pkg::DEPTH_W-1:0]        out_depth_q;

	// Stack memory: entries below height_q are valid
	logic [rpn_pkg::WORD_W-1:0]         stack_mem [rpn_pkg::STACK_DEPTH];
	logic [rpn_pkg::WORD_W-1:0]         rd_data_q;
	logic [rpn_pkg::PTR_W-1:0]          rd_addr;
	logic [rpn_pkg::PTR_W-1:0]          wr_addr;
	logic [rpn_pkg::WORD_W-1:0]         wr_data;
	logic                               wr_en;
	logic [rpn_pkg::HT_W-1:0]           height_m2;

	logic                               accept;
	logic                               full;
	logic                               few;
	logic                               out_free;
	rpn_pkg::alu_req_t                  alu_req;
	logic                               alu_done;
	logic [rpn_pkg::WORD_W-1:0]         alu_res;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (height_q >= rpn_pkg::HT_W'(rpn_pkg::STACK_DEPTH));
	assign few       = (height_q < rpn_pkg::HT_W'(2));
	assign height_m2 = height_q - rpn_pkg::HT_W'(2);
	assign rd_addr   = height_m2[rpn_pkg::PTR_W-1:0];

	// Memory writes: push at acceptance, operator result at completion
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = height_q[rpn_pkg::PTR_W-1:0];
		wr_data = operand_value;
		if (state_q == S_IDLE) begin
			wr_en = accept && !halted_q && (action == rpn_pkg::ACT_PUSH) && !full;
		end else if (state_q == S_WAIT) begin
			wr_en   = alu_done;
			wr_addr = rd_addr;
			wr_data = alu_res;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	// Shared unit starts once the left operand has been read
	assign alu_req.start = (state_q == S_START);
	assign alu_req.op    = op_q;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_data_q),
		.b      (top_q),
		.done   (alu_done),
		.res    (alu_res)
	);

	// Item sequencer, stack state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			height_q    <= '0;
			halted_q    <= 1'b0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= rpn_pkg::ALU_ADD;
		end else begin
			// result register loads from the emit state, holds while stalled
			out_valid_q <= (state_q == S_EMIT && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (halted_q) begin
							pend_status_q <= rpn_pkg::ST_HALTED;
							pend_value_q  <= top_q;
							state_q       <= S_EMIT;
						end else begin
							unique case (action) inside
								rpn_pkg::ACT_PUSH: begin
									state_q <= S_EMIT;
									if (full) begin
										pend_status_q <= rpn_pkg::ST_OVERFLOW;
										pend_value_q  <= top_q;
										halted_q      <= 1'b1;
									end else begin
										pend_status_q <= rpn_pkg::ST_OK;
										pend_value_q  <= operand_value;
										top_q         <= operand_value;
										height_q      <= height_q + 1'b1;
									end
								end
								rpn_pkg::ACT_END: begin
									state_q      <= S_EMIT;
									pend_value_q <= top_q;
									if (height_q != rpn_pkg::HT_W'(1)) begin
										pend_status_q <= rpn_pkg::ST_MISPLACED;
										halted_q      <= 1'b1;
									end else begin
										pend_status_q <= rpn_pkg::ST_RESULT;
										top_q         <= '0;
										height_q      <= '0;
									end
								end
								rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL,
								rpn_pkg::ACT_QUO, rpn_pkg::ACT_REM: begin
									if (few) begin
										pend_status_q <= rpn_pkg::ST_UNDERFLOW;
										pend_value_q  <= top_q;
										halted_q      <= 1'b1;
										state_q       <= S_EMIT;
									end else if ((action == rpn_pkg::ACT_QUO ||
										action == rpn_pkg::ACT_REM) && top_q == '0) begin
										pend_status_q <= rpn_pkg::ST_DIVZERO;
										pend_value_q  <= top_q;
										halted_q      <= 1'b1;
										state_q       <= S_EMIT;
									end else begin
										pend_status_q <= rpn_pkg::ST_OK;
										state_q       <= S_START;
										case (action)
											rpn_pkg::ACT_ADD: op_q <= rpn_pkg::ALU_ADD;
											rpn_pkg::ACT_SUB: op_q <= rpn_pkg::ALU_SUB;
											rpn_pkg::ACT_MUL: op_q <= rpn_pkg::ALU_MUL;
											rpn_pkg::ACT_QUO: op_q <= rpn_pkg::ALU_QUO;
											default:          op_q <= rpn_pkg::ALU_REM;
										endcase
									end
								end
								default: begin
									// unused code: reported as ok, stack untouched
									pend_status_q <= rpn_pkg::ST_OK;
									pend_value_q  <= top_q;
									state_q       <= S_EMIT;
								end
							endcase
						end
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_done) begin
						pend_value_q <= alu_res;
						top_q        <= alu_res;
						height_q     <= height_q - 1'b1;
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= pend_status_q;
						out_value_q  <= pend_value_q;
						out_depth_q  <= rpn_pkg::DEPTH_W'(height_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_value = out_value_q;
	assign stack_depth  = out_depth_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while previous transaction in work");

	a_height_bound: assert property (@(posedge clk) disable iff (!arst_n)
		height_q <= rpn_pkg::HT_W'(rpn_pkg::STACK_DEPTH))
		else $error("stack height beyond depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_WAIT))
		else $error("arithmetic unit finished outside wait state");

endmodule
